[rtl/mse_pkg.sv]
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants, opcode and function codes, and the execute result type
// for the MIPS subset execute unit.
// ----------------------------------------------------------------------------
package mse_pkg;

  // default size of the data window in words
  localparam int unsigned DATA_WORDS_DEF = 1024;

  // register file geometry
  localparam int unsigned RF_DEPTH = 32;
  localparam int unsigned RF_AW    = 5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INSN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE  = 2'd2;

  // reset values of the configuration registers
  localparam logic [31:0] TEXT_BASE_RST  = 32'h0040_0000;
  localparam logic [20:0] INSN_COUNT_RST = 21'd0;
  localparam logic [31:0] DATA_BASE_RST  = 32'h1000_0000;

  // major opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // register-format function codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  // link register for jal
  localparam logic [RF_AW-1:0] REG_RA = 5'd31;

  // outcome of the execute stage for one instruction
  typedef struct packed {
    logic [31:0]      npc;       // next program counter
    logic             live;      // executed (unit was running)
    logic             wr;        // register write, never to $0
    logic [RF_AW-1:0] widx;      // register written, zero when no write
    logic [31:0]      wval;      // value written, zero for loads and no write
    logic             load;      // load with a live destination
    logic             store;     // store inside the window
    logic             fault;     // access outside the data window
    logic [29:0]      word_off;  // word offset into the data window
  } exe_res_t;

  // sign-extend a 16-bit immediate
  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

[rtl/mse_ram.sv]
// ----------------------------------------------------------------------------
// mse_ram
// Generic single-write, single-read synchronous RAM with a registered read
// port and a read enable that holds the output when low.
// ----------------------------------------------------------------------------
module mse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/mse_regfile.sv]
// ----------------------------------------------------------------------------
// mse_regfile
// 32-word register file: two RAM copies give two read ports, per-entry valid
// bits make unwritten registers (and $0) read as zero after reset.
// ----------------------------------------------------------------------------
module mse_regfile (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [mse_pkg::RF_AW-1:0] rd_addr_a,
  input  logic [mse_pkg::RF_AW-1:0] rd_addr_b,
  output logic [31:0]               rd_data_a,
  output logic [31:0]               rd_data_b,
  input  logic                      wr_en,
  input  logic [mse_pkg::RF_AW-1:0] wr_addr,
  input  logic [31:0]               wr_data
);
  import mse_pkg::*;

  logic [RF_DEPTH-1:0] vld_r;
  logic                vld_a_r;
  logic                vld_b_r;
  logic [31:0]         ram_a;
  logic [31:0]         ram_b;
  logic                wr_ok;

  // $0 is never stored
  assign wr_ok = wr_en && (wr_addr != '0);

  // rs copy
  mse_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr_a),
    .rdata (ram_a)
  );

  // rt copy
  mse_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr_b),
    .rdata (ram_b)
  );

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_ok) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // valid sampled alongside the ram read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (rd_en) begin
      vld_a_r <= vld_r[rd_addr_a];
      vld_b_r <= vld_r[rd_addr_b];
    end
  end

  assign rd_data_a = vld_a_r ? ram_a : 32'd0;
  assign rd_data_b = vld_b_r ? ram_b : 32'd0;

endmodule

[rtl/mse_dmem.sv]
// ----------------------------------------------------------------------------
// mse_dmem
// Data window memory: one synchronous RAM plus a clearing sweep after reset
// that writes zero to every word, one word per cycle.
// ----------------------------------------------------------------------------
module mse_dmem #(
  parameter int unsigned DATA_WORDS = mse_pkg::DATA_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  output logic                          busy,
  input  logic                          st_en,
  input  logic [$clog2(DATA_WORDS)-1:0] st_addr,
  input  logic [31:0]                   st_data,
  input  logic                          ld_en,
  input  logic [$clog2(DATA_WORDS)-1:0] ld_addr,
  output logic [31:0]                   ld_data
);
  import mse_pkg::*;

  localparam int unsigned AW = $clog2(DATA_WORDS);

  logic          clr_r;
  logic [AW-1:0] clr_idx_r;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      if (clr_idx_r == AW'(DATA_WORDS - 1)) begin
        clr_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  // write port shared by sweep and stores
  always_comb begin
    if (clr_r) begin
      we    = 1'b1;
      waddr = clr_idx_r;
      wdata = 32'd0;
    end else begin
      we    = st_en;
      waddr = st_addr;
      wdata = st_data;
    end
  end

  mse_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ld_en),
    .raddr (ld_addr),
    .rdata (ld_data)
  );

  assign busy = clr_r;

endmodule

[rtl/mse_alu.sv]
// ----------------------------------------------------------------------------
// mse_alu
// Execute stage logic: decodes one instruction, computes the register result,
// next PC, data address and window check.
// ----------------------------------------------------------------------------
module mse_alu #(
  parameter int unsigned DATA_WORDS = mse_pkg::DATA_WORDS_DEF
) (
  input  logic                      run,
  input  logic [31:0]               pc,
  input  logic [31:0]               data_base,
  input  logic [5:0]                op,
  input  logic [5:0]                fn,
  input  logic [mse_pkg::RF_AW-1:0] rt,
  input  logic [mse_pkg::RF_AW-1:0] rd,
  input  logic [4:0]                sh,
  input  logic [15:0]               imm,
  input  logic [25:0]               tgt,
  input  logic [31:0]               a,
  input  logic [31:0]               b,
  output mse_pkg::exe_res_t         res
);
  import mse_pkg::*;

  logic [31:0] se;
  logic [31:0] pc4;
  logic [31:0] br_tgt;
  logic [31:0] j_tgt;
  logic [31:0] addr;
  logic [31:0] off;
  logic        in_win;
  logic        is_lw;

  // shared address arithmetic
  assign se     = sext16(imm);
  assign pc4    = pc + 32'd4;
  assign br_tgt = pc4 + {se[29:0], 2'b00};
  assign j_tgt  = {pc4[31:28], tgt, 2'b00};
  assign addr   = a + se;
  assign off    = addr - data_base;
  assign in_win = off[31:2] < 30'(DATA_WORDS);

  // decode and result select
  always_comb begin
    res          = '0;
    res.npc      = pc4;
    res.live     = 1'b1;
    res.word_off = off[31:2];
    is_lw        = 1'b0;
    case (op)
      OP_SPECIAL: begin
        res.wr   = 1'b1;
        res.widx = rd;
        case (fn)
          FN_ADDU: res.wval = a + b;
          FN_AND:  res.wval = a & b;
          FN_NOR:  res.wval = ~(a | b);
          FN_OR:   res.wval = a | b;
          FN_SLTU: res.wval = {31'd0, a < b};
          FN_SLL:  res.wval = b << sh;
          FN_SRL:  res.wval = b >> sh;
          FN_SUBU: res.wval = a - b;
          FN_JR: begin
            res.wr  = 1'b0;
            res.npc = a;
          end
          default: res.wr = 1'b0;
        endcase
      end
      OP_ADDIU: begin
        res.wr   = 1'b1;
        res.widx = rt;
        res.wval = a + se;
      end
      OP_ANDI: begin
        res.wr   = 1'b1;
        res.widx = rt;
        res.wval = a & {16'd0, imm};
      end
      OP_ORI: begin
        res.wr   = 1'b1;
        res.widx = rt;
        res.wval = a | {16'd0, imm};
      end
      OP_SLTIU: begin
        res.wr   = 1'b1;
        res.widx = rt;
        res.wval = {31'd0, a < se};
      end
      OP_LUI: begin
        res.wr   = 1'b1;
        res.widx = rt;
        res.wval = {imm, 16'd0};
      end
      OP_BEQ: begin
        if (a == b) begin
          res.npc = br_tgt;
        end
      end
      OP_BNE: begin
        if (a != b) begin
          res.npc = br_tgt;
        end
      end
      OP_LW: begin
        res.wr    = 1'b1;
        res.widx  = rt;
        res.fault = !in_win;
        is_lw     = 1'b1;
      end
      OP_SW: begin
        res.store = in_win;
        res.fault = !in_win;
      end
      OP_J: begin
        res.npc = j_tgt;
      end
      OP_JAL: begin
        res.wr   = 1'b1;
        res.widx = REG_RA;
        res.wval = pc4;
        res.npc  = j_tgt;
      end
      default: ;
    endcase

    // writes to $0 are dropped
    if (res.wr && (res.widx == '0)) begin
      res.wr = 1'b0;
    end
    if (!res.wr) begin
      res.widx = '0;
      res.wval = 32'd0;
    end
    res.load = is_lw && res.wr;

    // stopped unit holds everything
    if (!run) begin
      res      = '0;
      res.npc  = pc;
      res.word_off = off[31:2];
    end
  end

endmodule

[rtl/mips_subset_instruction_execute_unit.sv]
// ----------------------------------------------------------------------------
// mips_subset_instruction_execute_unit
// Executes one decoded MIPS-32 subset instruction per input beat against an
// internal PC, register file and windowed data memory.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  in_*      input      in_tvalid/in_tready   decoded instruction fields
//  out_*     output     out_tvalid/out_tready next pc, run, write, fault
//  cfg_*     input      cfg_we                register index and value
//
//  Pipeline: register read, execute (pc, store, load issue), memory/write
//  back, output register. One beat per cycle sustained while out_tready
//  holds; a load followed by an instruction whose rs or rt field names the
//  load destination holds that instruction in execute until the load leaves
//  write-back, since the data ram read is registered.
//  After reset the data ram is swept to zero with in_tready low;
//  configuration writes are taken during the sweep.
//  A stalled output holds the pipeline stage by stage; earlier stages keep
//  filling until they meet the held beat.
//
module mips_subset_instruction_execute_unit #(
  parameter int unsigned DATA_WORDS = mse_pkg::DATA_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // op, function, rs, rt, rd, shamt, immediate, jump target, zero pad
  input  logic [79:0]                   in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // next_pc, running, write_valid, write_index, write_value, access_fault
  output logic [71:0]                   out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_we,
  input  logic [mse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata
);
  import mse_pkg::*;

  localparam int unsigned AW = $clog2(DATA_WORDS);

  // input field split
  logic [5:0]       in_op;
  logic [5:0]       in_fn;
  logic [RF_AW-1:0] in_rs;
  logic [RF_AW-1:0] in_rt;
  logic [RF_AW-1:0] in_rd;
  logic [4:0]       in_sh;
  logic [15:0]      in_imm;
  logic [25:0]      in_tgt;

  assign in_op  = in_tdata[5:0];
  assign in_fn  = in_tdata[11:6];
  assign in_rs  = in_tdata[16:12];
  assign in_rt  = in_tdata[21:17];
  assign in_rd  = in_tdata[26:22];
  assign in_sh  = in_tdata[31:27];
  assign in_imm = in_tdata[47:32];
  assign in_tgt = in_tdata[73:48];

  // configuration and architectural state
  logic [31:0] text_base_r;
  logic [20:0] icount_r;
  logic [31:0] data_base_r;
  logic [31:0] pc_r;
  logic        run_r;

  // execute stage
  logic             s1_valid_r;
  logic [5:0]       s1_op_r;
  logic [5:0]       s1_fn_r;
  logic [RF_AW-1:0] s1_rs_r;
  logic [RF_AW-1:0] s1_rt_r;
  logic [RF_AW-1:0] s1_rd_r;
  logic [4:0]       s1_sh_r;
  logic [15:0]      s1_imm_r;
  logic [25:0]      s1_tgt_r;
  logic             ovr_a_v_r;
  logic [31:0]      ovr_a_r;
  logic             ovr_b_v_r;
  logic [31:0]      ovr_b_r;

  // memory / write-back stage
  logic             s2_valid_r;
  logic [31:0]      s2_npc_r;
  logic             s2_live_r;
  logic             s2_wr_r;
  logic [RF_AW-1:0] s2_widx_r;
  logic [31:0]      s2_wval_r;
  logic             s2_load_r;
  logic             s2_fault_r;

  // output register
  logic             out_valid_r;
  logic [71:0]      out_data_r;

  // handshake and hazard control
  logic        in_fire;
  logic        out_load;
  logic        s2_go;
  logic        s1_go;
  logic        hazard;
  logic        run_eff;
  logic [31:0] stop_diff;
  logic        s2_stop;
  logic [31:0] s2_res_val;
  logic        rf_we;
  logic        out_valid_nxt;

  // operand path
  logic [31:0] rf_a;
  logic [31:0] rf_b;
  logic        fwd_a;
  logic        fwd_b;
  logic [31:0] op_a;
  logic [31:0] op_b;
  exe_res_t    res;

  // data memory
  logic        dm_busy;
  logic        dm_ld_en;
  logic        dm_st_en;
  logic [31:0] dm_ld_data;

  // flow control
  assign out_load = !out_valid_r || out_tready;
  assign s2_go    = s2_valid_r && out_load;
  assign hazard   = s2_valid_r && s2_load_r
                    && ((s2_widx_r == s1_rs_r) || (s2_widx_r == s1_rt_r));
  assign s1_go    = s1_valid_r && !hazard && (!s2_valid_r || s2_go);
  assign in_tready = !dm_busy && (!s1_valid_r || s1_go);
  assign in_fire  = in_tvalid && in_tready;

  // stop test on the pc leaving write-back
  assign stop_diff = s2_npc_r - text_base_r;
  assign s2_stop   = stop_diff[31:2] == {9'd0, icount_r};
  assign run_eff   = run_r && !(s2_valid_r && s2_live_r && s2_stop);

  // write-back value and register write
  assign s2_res_val = s2_load_r ? (s2_fault_r ? 32'd0 : dm_ld_data) : s2_wval_r;
  assign rf_we      = s2_go && s2_wr_r;

  mse_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_fire),
    .rd_addr_a (in_rs),
    .rd_addr_b (in_rt),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b),
    .wr_en     (rf_we),
    .wr_addr   (s2_widx_r),
    .wr_data   (s2_res_val)
  );

  // operand select: write-back stage, then captured writes, then the file
  assign fwd_a = s2_valid_r && s2_wr_r && !s2_load_r && (s2_widx_r == s1_rs_r);
  assign fwd_b = s2_valid_r && s2_wr_r && !s2_load_r && (s2_widx_r == s1_rt_r);
  assign op_a  = fwd_a ? s2_wval_r : (ovr_a_v_r ? ovr_a_r : rf_a);
  assign op_b  = fwd_b ? s2_wval_r : (ovr_b_v_r ? ovr_b_r : rf_b);

  mse_alu #(.DATA_WORDS(DATA_WORDS)) u_alu (
    .run       (run_eff),
    .pc        (pc_r),
    .data_base (data_base_r),
    .op        (s1_op_r),
    .fn        (s1_fn_r),
    .rt        (s1_rt_r),
    .rd        (s1_rd_r),
    .sh        (s1_sh_r),
    .imm       (s1_imm_r),
    .tgt       (s1_tgt_r),
    .a         (op_a),
    .b         (op_b),
    .res       (res)
  );

  // data memory access from the execute stage
  assign dm_ld_en = s1_go && res.load && !res.fault;
  assign dm_st_en = s1_go && res.store;

  mse_dmem #(.DATA_WORDS(DATA_WORDS)) u_dmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .busy    (dm_busy),
    .st_en   (dm_st_en),
    .st_addr (res.word_off[AW-1:0]),
    .st_data (op_b),
    .ld_en   (dm_ld_en),
    .ld_addr (res.word_off[AW-1:0]),
    .ld_data (dm_ld_data)
  );

  // configuration registers and program counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_base_r <= TEXT_BASE_RST;
      icount_r    <= INSN_COUNT_RST;
      data_base_r <= DATA_BASE_RST;
      pc_r        <= TEXT_BASE_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TEXT_BASE:  text_base_r <= cfg_wdata;
          CFG_INSN_COUNT: icount_r    <= cfg_wdata[20:0];
          CFG_DATA_BASE:  data_base_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cfg_we && (cfg_index == CFG_TEXT_BASE)) begin
        pc_r <= cfg_wdata;
      end else if (s1_go) begin
        pc_r <= res.npc;
      end
    end
  end

  // run flag drops when a live instruction reaches the count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b1;
    end else if (s2_go && s2_live_r && s2_stop) begin
      run_r <= 1'b0;
    end
  end

  // execute stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  // execute stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r  <= in_op;
      s1_fn_r  <= in_fn;
      s1_rs_r  <= in_rs;
      s1_rt_r  <= in_rt;
      s1_rd_r  <= in_rd;
      s1_sh_r  <= in_sh;
      s1_imm_r <= in_imm;
      s1_tgt_r <= in_tgt;
    end
  end

  // capture register writes the ram read cannot see yet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovr_a_v_r <= 1'b0;
      ovr_b_v_r <= 1'b0;
    end else if (in_fire) begin
      ovr_a_v_r <= rf_we && (s2_widx_r == in_rs);
      ovr_b_v_r <= rf_we && (s2_widx_r == in_rt);
    end else begin
      if (rf_we && (s2_widx_r == s1_rs_r)) begin
        ovr_a_v_r <= 1'b1;
      end
      if (rf_we && (s2_widx_r == s1_rt_r)) begin
        ovr_b_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire ? (rf_we && (s2_widx_r == in_rs)) : (rf_we && (s2_widx_r == s1_rs_r))) begin
      ovr_a_r <= s2_res_val;
    end
    if (in_fire ? (rf_we && (s2_widx_r == in_rt)) : (rf_we && (s2_widx_r == s1_rt_r))) begin
      ovr_b_r <= s2_res_val;
    end
  end

  // write-back stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_go) begin
      s2_valid_r <= 1'b1;
    end else if (s2_go) begin
      s2_valid_r <= 1'b0;
    end
  end

  // write-back stage payload
  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_npc_r   <= res.npc;
      s2_live_r  <= res.live;
      s2_wr_r    <= res.wr;
      s2_widx_r  <= res.widx;
      s2_wval_r  <= res.wval;
      s2_load_r  <= res.load;
      s2_fault_r <= res.fault;
    end
  end

  // output register
  assign out_valid_nxt = s2_go || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_data_r <= {s2_fault_r, s2_res_val, s2_widx_r, s2_wr_r,
                     s2_live_r && !s2_stop, s2_npc_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // register $0 is never written
  a_no_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> (s2_widx_r != '0))
    else $error("register write to $0");

  // a stopped unit writes no register and no memory
  a_stopped_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !run_r |-> (!rf_we && !dm_st_en))
    else $error("state change after stop");

  // no store reaches the data ram during the clearing sweep
  a_no_store_clear: assert property (@(posedge clk) disable iff (!rst_n)
    dm_busy |-> (!dm_st_en && !s1_valid_r))
    else $error("store during clearing sweep");

  // a held load-use stall keeps both the load and the waiting instruction
  a_hazard_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (hazard && s1_valid_r && !s2_go) |=> (s1_valid_r && s2_valid_r))
    else $error("load-use hazard lost an item");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams decoded MIPS subset instructions into the execute unit in bursts
// and checks every retired beat against an in-bench model of the PC,
// register file, data window and run flag, over several base and count
// settings ending with the unit running into its stop point.
// ----------------------------------------------------------------------------
module tb_top;
  import mse_pkg::*;

  localparam int unsigned DMEM_WORDS  = DATA_WORDS_DEF;
  localparam int unsigned STUCK_LIMIT = 4 * DMEM_WORDS + 2000;
  localparam logic [4:0]  PTR_REG     = 5'd28;
  localparam logic [5:0]  OP_UNDEF    = 6'h3f;
  localparam logic [5:0]  FN_UNDEF    = 6'h3f;

  // one decoded instruction, op in the low bits
  typedef struct packed {
    logic [25:0] tgt;
    logic [15:0] imm;
    logic [4:0]  sh;
    logic [4:0]  rd;
    logic [4:0]  rt;
    logic [4:0]  rs;
    logic [5:0]  fn;
    logic [5:0]  op;
  } insn_t;

  // one retired instruction, next pc in the low bits
  typedef struct packed {
    logic        fault;
    logic [31:0] wval;
    logic [4:0]  widx;
    logic        wr;
    logic        run;
    logic [31:0] npc;
  } retire_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic [79:0]          in_tdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [71:0]          out_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_wdata = '0;

  // architectural state mirrored by the bench
  logic [31:0] text_base_q  = TEXT_BASE_RST;
  logic [20:0] insn_count_q = INSN_COUNT_RST;
  logic [31:0] data_base_q  = DATA_BASE_RST;
  logic [31:0] cpu_pc       = TEXT_BASE_RST;
  logic        cpu_run      = 1'b1;
  logic [31:0] cpu_regs [RF_DEPTH];
  logic [31:0] cpu_dmem [DMEM_WORDS];

  insn_t       insn_q [$];
  retire_t     retire_q [$];
  int unsigned mismatches = 0;
  int unsigned stuck_cycles = 0;

  mips_subset_instruction_execute_unit #(
    .DATA_WORDS(DMEM_WORDS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    for (int k = 0; k < RF_DEPTH; k++) cpu_regs[k] = '0;
    for (int k = 0; k < DMEM_WORDS; k++) cpu_dmem[k] = '0;
  end

  // execute one instruction on the mirrored state, return the retired beat
  function automatic retire_t exec_insn(input insn_t i);
    retire_t     r;
    logic [31:0] a, b, se, pc4, npc, off, wval;
    logic [4:0]  widx;
    logic        wr, fault, hit;
    r = '0;
    if (!cpu_run) begin
      r.npc = cpu_pc;
      return r;
    end
    a     = cpu_regs[i.rs];
    b     = cpu_regs[i.rt];
    se    = {{16{i.imm[15]}}, i.imm};
    pc4   = cpu_pc + 32'd4;
    npc   = pc4;
    wr    = 1'b0;
    widx  = '0;
    wval  = '0;
    fault = 1'b0;
    off   = a + se - data_base_q;
    hit   = (off[31:2] < DMEM_WORDS);
    if (i.op == OP_SPECIAL) begin
      wr   = 1'b1;
      widx = i.rd;
      case (i.fn)
        FN_ADDU: wval = a + b;
        FN_AND:  wval = a & b;
        FN_NOR:  wval = ~(a | b);
        FN_OR:   wval = a | b;
        FN_SLTU: wval = (a < b) ? 32'd1 : 32'd0;
        FN_SLL:  wval = b << i.sh;
        FN_SRL:  wval = b >> i.sh;
        FN_SUBU: wval = a - b;
        FN_JR: begin
          wr  = 1'b0;
          npc = a;
        end
        default: wr = 1'b0;
      endcase
    end else begin
      case (i.op)
        OP_ADDIU: begin
          wr = 1'b1; widx = i.rt; wval = a + se;
        end
        OP_ANDI: begin
          wr = 1'b1; widx = i.rt; wval = a & {16'd0, i.imm};
        end
        OP_ORI: begin
          wr = 1'b1; widx = i.rt; wval = a | {16'd0, i.imm};
        end
        OP_SLTIU: begin
          wr = 1'b1; widx = i.rt; wval = (a < se) ? 32'd1 : 32'd0;
        end
        OP_LUI: begin
          wr = 1'b1; widx = i.rt; wval = {i.imm, 16'd0};
        end
        OP_BEQ: if (a == b) npc = pc4 + (se << 2);
        OP_BNE: if (a != b) npc = pc4 + (se << 2);
        OP_LW: begin
          wr   = 1'b1;
          widx = i.rt;
          if (hit) wval = cpu_dmem[off[31:2]];
          else fault = 1'b1;
        end
        OP_SW: begin
          if (hit) cpu_dmem[off[31:2]] = b;
          else fault = 1'b1;
        end
        OP_J: npc = {pc4[31:28], i.tgt, 2'b00};
        OP_JAL: begin
          wr   = 1'b1;
          widx = REG_RA;
          wval = pc4;
          npc  = {pc4[31:28], i.tgt, 2'b00};
        end
        default: ;
      endcase
    end
    // $0 stays zero and is reported as no write
    if (wr && widx == '0) wr = 1'b0;
    if (wr) begin
      cpu_regs[widx] = wval;
    end else begin
      widx = '0;
      wval = '0;
    end
    cpu_pc = npc;
    if (((npc - text_base_q) >> 2) == {11'd0, insn_count_q}) cpu_run = 1'b0;
    r.npc   = npc;
    r.run   = cpu_run;
    r.wr    = wr;
    r.widx  = widx;
    r.wval  = wval;
    r.fault = fault;
    return r;
  endfunction

  function automatic string fmt_retire(input retire_t r);
    return $sformatf("pc=%h run=%0b wr=%0b idx=%0d val=%h fault=%0b",
                     r.npc, r.run, r.wr, r.widx, r.wval, r.fault);
  endfunction

  // all fields random, so unused fields toggle too
  function automatic insn_t noise_insn();
    logic [95:0] r;
    r = {$urandom(), $urandom(), $urandom()};
    return r[73:0];
  endfunction

  function automatic insn_t mk_r(input logic [5:0] fn, input logic [4:0] rs,
                                 input logic [4:0] rt, input logic [4:0] rd,
                                 input logic [4:0] sh);
    insn_t i;
    i    = noise_insn();
    i.op = OP_SPECIAL;
    i.fn = fn;
    i.rs = rs;
    i.rt = rt;
    i.rd = rd;
    i.sh = sh;
    return i;
  endfunction

  function automatic insn_t mk_i(input logic [5:0] op, input logic [4:0] rs,
                                 input logic [4:0] rt, input logic [15:0] imm);
    insn_t i;
    i     = noise_insn();
    i.op  = op;
    i.rs  = rs;
    i.rt  = rt;
    i.imm = imm;
    return i;
  endfunction

  function automatic insn_t mk_j(input logic [5:0] op, input logic [25:0] tgt);
    insn_t i;
    i     = noise_insn();
    i.op  = op;
    i.tgt = tgt;
    return i;
  endfunction

  // mostly low registers so the data pointer in $28 survives a while
  function automatic logic [4:0] pick_dest();
    return ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                       : 5'($urandom_range(0, 27));
  endfunction

  // random instruction; no_flow keeps the pc moving straight ahead
  function automatic insn_t rand_insn(input bit no_flow);
    insn_t       i;
    int unsigned pick;
    bit          retry;
    i    = noise_insn();
    pick = $urandom_range(0, 99);
    if (no_flow && ((pick >= 80 && pick < 94) || pick >= 97))
      pick = $urandom_range(0, 79);
    if (pick < 38) begin
      i.op = OP_SPECIAL;
      i.rd = pick_dest();
      case ($urandom_range(0, 7))
        0: i.fn = FN_ADDU;
        1: i.fn = FN_AND;
        2: i.fn = FN_NOR;
        3: i.fn = FN_OR;
        4: i.fn = FN_SLTU;
        5: i.fn = FN_SLL;
        6: i.fn = FN_SRL;
        default: i.fn = FN_SUBU;
      endcase
    end else if (pick < 58) begin
      i.rt = pick_dest();
      case ($urandom_range(0, 4))
        0: i.op = OP_ADDIU;
        1: i.op = OP_SLTIU;
        2: i.op = OP_ANDI;
        3: i.op = OP_ORI;
        default: i.op = OP_LUI;
      endcase
    end else if (pick < 80) begin
      // loads and stores through the data pointer, some outside the window
      i.op = ($urandom_range(0, 1) != 0) ? OP_LW : OP_SW;
      if (i.op == OP_LW) i.rt = pick_dest();
      if ($urandom_range(0, 9) != 0) i.rs = PTR_REG;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: i.imm = 16'($urandom_range(0, 255));
        5, 6, 7:       i.imm = 16'($urandom_range(0, 4 * DMEM_WORDS - 1));
        default: ;
      endcase
    end else if (pick < 87) begin
      i.op = ($urandom_range(0, 1) != 0) ? OP_BEQ : OP_BNE;
      if ($urandom_range(0, 1) != 0) i.rt = i.rs;
      if ($urandom_range(0, 3) != 0) i.imm = 16'($urandom_range(0, 32) - 16);
    end else if (pick < 91) begin
      i.op = ($urandom_range(0, 1) != 0) ? OP_J : OP_JAL;
    end else if (pick < 94) begin
      i.op = OP_SPECIAL;
      i.fn = FN_JR;
    end else if (pick < 97) begin
      // undefined opcode or function code: pc only
      if ($urandom_range(0, 1) != 0) begin
        do begin
          i.op = 6'($urandom_range(1, 63));
          case (i.op)
            OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDIU, OP_SLTIU, OP_ANDI, OP_ORI,
            OP_LUI, OP_LW, OP_SW: retry = 1'b1;
            default: retry = 1'b0;
          endcase
        end while (retry);
      end else begin
        i.op = OP_SPECIAL;
        do begin
          i.fn = 6'($urandom_range(0, 63));
          case (i.fn)
            FN_SLL, FN_SRL, FN_JR, FN_ADDU, FN_SUBU, FN_AND, FN_OR, FN_NOR,
            FN_SLTU: retry = 1'b1;
            default: retry = 1'b0;
          endcase
        end while (retry);
      end
    end
    return i;
  endfunction

  // random program with the data pointer reloaded now and then
  task automatic queue_random(input int unsigned n, input bit no_flow);
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 24 == 0) begin
        insn_q.push_back(mk_i(OP_LUI, 5'd0, PTR_REG, data_base_q[31:16]));
        insn_q.push_back(mk_i(OP_ORI, PTR_REG, PTR_REG, data_base_q[15:0]));
      end
      insn_q.push_back(rand_insn(no_flow));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_TEXT_BASE: begin
        text_base_q = val;
        cpu_pc      = val;
      end
      CFG_INSN_COUNT: insn_count_q = val[20:0];
      CFG_DATA_BASE:  data_base_q  = val;
      default: ;
    endcase
  endtask

  task automatic start_phase(input logic [31:0] tbase, input logic [31:0] count,
                             input logic [31:0] dbase);
    write_reg(CFG_TEXT_BASE, tbase);
    write_reg(CFG_INSN_COUNT, count);
    write_reg(CFG_DATA_BASE, dbase);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for every beat to go in and come back, then let the pipe settle
  task automatic drain(input int unsigned settle);
    while (insn_q.size() != 0 || in_tvalid || retire_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // sender: bursts of random length with random gaps
  insn_t       drv_insn;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) retire_q.push_back(exec_insn(drv_insn));
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (insn_q.size() != 0) begin
          drv_insn = insn_q.pop_front();
          in_tdata  <= {6'd0, drv_insn};
          in_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall modes that change when a random countdown runs out
  int unsigned rdy_mode = 0;
  int unsigned rdy_left = 0;

  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode <= $urandom_range(0, 3);
      rdy_left <= $urandom_range(16, 96);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    case (rdy_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 9) < 3);
      default: out_tready <= rdy_left[3];
    endcase
  end

  // result check against the oldest prediction
  always @(posedge clk) begin : result_check
    retire_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = retire_t'(out_tdata);
      if (retire_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result beat with nothing pending: %s", fmt_retire(got));
      end else begin
        want = retire_q.pop_front();
        if (got.npc !== want.npc || got.run !== want.run || got.wr !== want.wr ||
            got.widx !== want.widx || got.wval !== want.wval ||
            got.fault !== want.fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result mismatch\n  exp %s\n  got %s",
                     fmt_retire(want), fmt_retire(got));
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // stimulus phases
  initial begin : stimulus
    int unsigned stop_at;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset bases, count with only bit 20 set in the 21-bit field and junk above it
    start_phase(TEXT_BASE_RST, 32'hfff0_0000, DATA_BASE_RST);
    insn_q.push_back(mk_i(OP_LUI, 5'd0, PTR_REG, 16'h1000));
    insn_q.push_back(mk_i(OP_LUI, 5'd0, 5'd1, 16'hffff));
    insn_q.push_back(mk_i(OP_ORI, 5'd1, 5'd1, 16'hffff));
    insn_q.push_back(mk_i(OP_ADDIU, 5'd0, 5'd2, 16'h8000));
    insn_q.push_back(mk_i(OP_ADDIU, 5'd0, 5'd3, 16'h7fff));
    insn_q.push_back(mk_i(OP_ANDI, 5'd1, 5'd4, 16'hffff));
    insn_q.push_back(mk_i(OP_SLTIU, 5'd0, 5'd5, 16'hffff));
    insn_q.push_back(mk_r(FN_ADDU, 5'd1, 5'd3, 5'd6, 5'd0));
    insn_q.push_back(mk_r(FN_SUBU, 5'd0, 5'd3, 5'd7, 5'd0));
    insn_q.push_back(mk_r(FN_AND, 5'd1, 5'd2, 5'd8, 5'd0));
    insn_q.push_back(mk_r(FN_OR, 5'd2, 5'd3, 5'd9, 5'd0));
    insn_q.push_back(mk_r(FN_NOR, 5'd0, 5'd0, 5'd10, 5'd0));
    insn_q.push_back(mk_r(FN_SLTU, 5'd0, 5'd1, 5'd11, 5'd0));
    insn_q.push_back(mk_r(FN_SLL, 5'd0, 5'd1, 5'd12, 5'd31));
    insn_q.push_back(mk_r(FN_SRL, 5'd0, 5'd1, 5'd13, 5'd31));
    // write to $0 is dropped
    insn_q.push_back(mk_r(FN_ADDU, 5'd1, 5'd1, 5'd0, 5'd0));
    // window edges, unaligned and just outside on both sides
    insn_q.push_back(mk_i(OP_SW, PTR_REG, 5'd1, 16'h0000));
    insn_q.push_back(mk_i(OP_SW, PTR_REG, 5'd3, 16'h0ffc));
    insn_q.push_back(mk_i(OP_LW, PTR_REG, 5'd14, 16'h0ffe));
    insn_q.push_back(mk_i(OP_LW, PTR_REG, 5'd15, 16'h1000));
    insn_q.push_back(mk_i(OP_SW, PTR_REG, 5'd1, 16'hfffc));
    insn_q.push_back(mk_i(OP_LW, PTR_REG, 5'd16, 16'h0003));
    // branches taken, not taken and backwards, then jumps
    insn_q.push_back(mk_i(OP_BEQ, 5'd1, 5'd1, 16'h0002));
    insn_q.push_back(mk_i(OP_BNE, 5'd1, 5'd1, 16'h0005));
    insn_q.push_back(mk_i(OP_BNE, 5'd1, 5'd0, 16'hffff));
    insn_q.push_back(mk_j(OP_JAL, 26'h0));
    insn_q.push_back(mk_r(FN_JR, REG_RA, 5'd0, 5'd0, 5'd0));
    insn_q.push_back(mk_j(OP_J, 26'h3ff_ffff));
    insn_q.push_back(mk_i(OP_UNDEF, 5'd1, 5'd2, 16'h1234));
    insn_q.push_back(mk_r(FN_UNDEF, 5'd1, 5'd2, 5'd3, 5'd4));
    queue_random(200, 1'b0);
    drain(8);

    // pc wraps past the top, count zero, window at address zero
    start_phase(32'hffff_fff0, 32'd0, 32'd0);
    queue_random(150, 1'b1);
    drain(8);

    // random text base, window base at the very top and unaligned
    start_phase($urandom() & 32'hffff_fffc, $urandom_range(32'h1000, 32'h1f_ffff),
                32'hffff_ffff);
    queue_random(150, 1'b0);
    drain(8);

    // straight-line program that runs into its stop point, then stopped beats
    stop_at = $urandom_range(60, 90);
    start_phase($urandom() & 32'hffff_fffc, stop_at, $urandom() & 32'hffff_fffc);
    queue_random(stop_at + 20, 1'b1);
    drain(20);

    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
